FILE: rtl/core/archive_block_word_decrypt_assert.svh
// Assertion macros shared by the archive block word decryptor RTL.
`ifndef ARCHIVE_BLOCK_WORD_DECRYPT_ASSERT_SVH
`define ARCHIVE_BLOCK_WORD_DECRYPT_ASSERT_SVH

// The antecedent holding at an edge requires the consequent at the same edge.
`define ABWD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The antecedent holding at an edge requires the consequent at the next edge.
`define ABWD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

FILE: rtl/core/abwd_pkg.sv
// Package with the constants, types and key table of the block word decryptor.
package abwd_pkg;

	localparam logic [31:0] LCG_INIT   = 32'h0010_0001;
	localparam logic [31:0] LCG_MOD    = 32'h002A_AAAB;
	localparam logic [31:0] MIX_INIT   = 32'hEEEE_EEEE;
	localparam logic [31:0] ROT_ADD    = 32'h1111_1111;
	localparam int          TABLE_SIZE = 256;
	localparam int          SLICES     = 5;
	localparam int          KEEP_SLICE = 4;

	typedef logic [31:0] key_table_t [TABLE_SIZE];

	// Running chain state carried from word to word.
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] mix;
	} chain_t;

	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		logic [31:0] prod;
		prod = s * 32'd125 + 32'd3;
		return prod % LCG_MOD;
	endfunction

	// Runs the generator through all slices and keeps only the last one.
	function automatic key_table_t build_key_table();
		key_table_t  t;
		logic [31:0] s;
		logic [15:0] hi;
		s = LCG_INIT;
		for (int idx = 0; idx < TABLE_SIZE; idx++) begin
			for (int sl = 0; sl < SLICES; sl++) begin
				s  = lcg_next(s);
				hi = s[15:0];
				s  = lcg_next(s);
				if (sl == KEEP_SLICE) begin
					t[idx] = {hi, s[15:0]};
				end
			end
		end
		return t;
	endfunction

	localparam key_table_t KEY_TABLE = build_key_table();

endpackage

FILE: rtl/core/abwd_round.sv
// One decryption round: key table lookup, word decrypt and chain update.
module abwd_round (
	input  logic                  start_req,
	input  logic [31:0]           block_key,
	input  logic [31:0]           cipher_word,
	input  abwd_pkg::chain_t      chain_cur,
	output logic [31:0]           plain_word,
	output abwd_pkg::chain_t      chain_next
);
	import abwd_pkg::*;

	logic [31:0] key_cur;
	logic [31:0] mix_cur;
	logic [31:0] mix_add;
	logic [31:0] plain;

	// A start word restarts the chain before it is decrypted.
	assign key_cur = start_req ? block_key : chain_cur.key;
	assign mix_cur = start_req ? MIX_INIT : chain_cur.mix;

	assign mix_add = mix_cur + KEY_TABLE[key_cur[7:0]];
	assign plain   = cipher_word ^ (key_cur + mix_add);

	assign plain_word     = plain;
	assign chain_next.key = (((~key_cur) << 21) + ROT_ADD) | (key_cur >> 11);
	assign chain_next.mix = plain + mix_add + (mix_add << 5) + 32'd3;

endmodule

FILE: rtl/core/archive_block_word_decrypt.sv
// Top level of the archive block word decryptor.
//
// Input channel: in_valid/in_stall carry one word per handshake with fields
// start_req, block_key and cipher_word. A word with start_req set loads
// block_key and restarts the running mix; other words continue the chain.
// Output channel: out_valid/out_stall carry one plain_word per input word,
// in input order.
// Each accepted word is held in the input register, then the round logic
// writes the result register and the chain state together, and out_valid
// rises with the result register. Throughput is one word per cycle while
// out_stall is low, set by the chain feedback path of table lookup and adders.
// When the receiver stalls, the result register holds its word; the input
// register keeps accepting until it too is full, so in_stall rises only when
// both registers hold a word and out_stall is high.
// Reset clears both valid flags, sets the running key to zero and the
// running mix to EEEEEEEE hex, so a first word without a start decrypts as
// if key zero had been started.
module archive_block_word_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_req,
	input  logic [31:0] block_key,
	input  logic [31:0] cipher_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] plain_word
);
	import abwd_pkg::*;

	`include "archive_block_word_decrypt_assert.svh"

	logic        valid_s1;
	logic        start_s1;
	logic [31:0] key_s1;
	logic [31:0] cipher_s1;
	logic        valid_s2;
	logic [31:0] plain_s2;
	chain_t      chain_q;
	chain_t      chain_next;
	logic [31:0] plain_next;
	logic        adv;
	logic        in_acc;
	logic        out_acc;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = valid_s2 && !out_stall;

	abwd_round u_round (
		.start_req   (start_s1),
		.block_key   (key_s1),
		.cipher_word (cipher_s1),
		.chain_cur   (chain_q),
		.plain_word  (plain_next),
		.chain_next  (chain_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			start_s1  <= start_req;
			key_s1    <= block_key;
			cipher_s1 <= cipher_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			chain_q.key <= '0;
			chain_q.mix <= MIX_INIT;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			chain_q  <= chain_next;
		end else if (out_acc) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			plain_s2 <= plain_next;
		end
	end

	assign out_valid  = valid_s2;
	assign plain_word = plain_s2;

	`ABWD_ASSERT_IMP(a_stall_from_out, in_stall, out_valid && out_stall)
	`ABWD_ASSERT_NXT(a_held_word, valid_s1 && !adv, valid_s1 && $stable(cipher_s1))
	`ABWD_ASSERT_NXT(a_drain_empty, out_acc && !adv, !out_valid)

endmodule
